// File: src/mptt_pkg.sv
// Package for the multi-period timer: field widths, reset values, phase codes,
// register indexes and the item, result and configuration structs.
// No dependencies.
package mptt_pkg;

   localparam int unsigned PERIODS_WIDTH = 8;
   localparam int unsigned TIMEOUT_WIDTH = 24;
   localparam int unsigned ELAPSED_WIDTH = 24;

   localparam logic [PERIODS_WIDTH-1:0] PERIODS_RESET = 8'd50;
   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = 24'hffffff;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_SYNC_LOW  = 3'd1,
      PH_SYNC_HIGH = 3'd2,
      PH_MEAS_LOW  = 3'd3,
      PH_MEAS_HIGH = 3'd4
   } phase_type;

   typedef enum logic [0:0] {
      CSR_PERIODS = 1'b0,
      CSR_TIMEOUT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic func;
      logic pin_level;
   } item_type;

   typedef struct packed {
      logic [ELAPSED_WIDTH-1:0] elapsed_ticks;
      logic                     timed_out;
   } result_type;

   typedef struct packed {
      logic [PERIODS_WIDTH-1:0] periods_to_measure;
      logic [TIMEOUT_WIDTH-1:0] timeout_ticks;
   } cfg_type;

endpackage

// File: src/mptt_if.sv
// Channel interfaces of the multi-period timer: request, response and
// register write channels with valid/ready transfer. Depends on mptt_pkg.
interface mptt_req_if;
   logic valid;
   logic ready;
   logic func;
   logic pin_level;

   modport source (output valid, output func, output pin_level, input ready);
   modport sink (input valid, input func, input pin_level, output ready);
endinterface

interface mptt_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [mptt_pkg::ELAPSED_WIDTH-1:0]  elapsed_ticks;
   logic                                timed_out;

   modport source (output valid, output elapsed_ticks, output timed_out, input ready);
   modport sink (input valid, input elapsed_ticks, input timed_out, output ready);
endinterface

interface mptt_csr_if;
   logic                               valid;
   logic                               ready;
   mptt_pkg::csr_index_type            index;
   logic [mptt_pkg::TIMEOUT_WIDTH-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/mptt_csr.sv
// Configuration registers of the multi-period timer: period count and
// timeout window. Depends on mptt_pkg.
module mptt_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_valid,
   input  mptt_pkg::csr_index_type            wr_index,
   input  logic [mptt_pkg::TIMEOUT_WIDTH-1:0] wr_data,
   output mptt_pkg::cfg_type                  cfg
);

   logic [mptt_pkg::PERIODS_WIDTH-1:0] periods_ff, periods_in;
   logic [mptt_pkg::TIMEOUT_WIDTH-1:0] timeout_ff, timeout_in;

   always_comb begin
      periods_in = periods_ff;
      timeout_in = timeout_ff;
      if (wr_valid) begin
         unique case (wr_index)
            mptt_pkg::CSR_PERIODS: periods_in = wr_data[mptt_pkg::PERIODS_WIDTH-1:0];
            mptt_pkg::CSR_TIMEOUT: timeout_in = wr_data;
            default:               periods_in = periods_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         periods_ff <= mptt_pkg::PERIODS_RESET;
         timeout_ff <= mptt_pkg::TIMEOUT_RESET;
      end else begin
         periods_ff <= periods_in;
         timeout_ff <= timeout_in;
      end
   end

   assign cfg.periods_to_measure = periods_ff;
   assign cfg.timeout_ticks      = timeout_ff;

endmodule

// File: src/mptt_core.sv
// Phase state machine, window counter and period counter of the multi-period
// timer; one registered item is stepped per cycle while step is high. Depends on mptt_pkg.
module mptt_core #(
   parameter int unsigned COUNT_WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  mptt_pkg::item_type   item,
   input  mptt_pkg::cfg_type    cfg,
   output logic                 res_valid,
   output mptt_pkg::result_type result
);

   localparam int unsigned CMP_WIDTH =
      (COUNT_WIDTH > mptt_pkg::TIMEOUT_WIDTH) ? COUNT_WIDTH : mptt_pkg::TIMEOUT_WIDTH;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   mptt_pkg::phase_type phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0]             count_ff, count_in;
   logic [mptt_pkg::PERIODS_WIDTH-1:0] done_ff, done_in;

   logic [COUNT_WIDTH-1:0]             count_inc;
   logic [mptt_pkg::PERIODS_WIDTH-1:0] done_inc;
   logic                               expected;
   logic                               expired;

   always_comb begin
      count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      done_inc  = done_ff + 1'b1;
      expected  = (phase_ff == mptt_pkg::PH_SYNC_HIGH) || (phase_ff == mptt_pkg::PH_MEAS_HIGH);
      expired   = (CMP_WIDTH'(count_inc) >= CMP_WIDTH'(cfg.timeout_ticks))
                  || (count_inc == COUNT_MAX);

      phase_in  = phase_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      res_valid = 1'b0;
      result.elapsed_ticks = '0;
      result.timed_out     = 1'b0;

      if (step) begin
         if (item.func) begin
            phase_in = mptt_pkg::PH_SYNC_LOW;
            count_in = '0;
            done_in  = '0;
         end else if (phase_ff == mptt_pkg::PH_IDLE) begin
            phase_in = mptt_pkg::PH_IDLE;
         end else if (item.pin_level == expected) begin
            unique case (phase_ff)
               mptt_pkg::PH_SYNC_LOW: begin
                  phase_in = mptt_pkg::PH_SYNC_HIGH;
                  count_in = '0;
               end
               mptt_pkg::PH_SYNC_HIGH: begin
                  count_in = '0;
                  done_in  = '0;
                  if (cfg.periods_to_measure == '0) begin
                     phase_in  = mptt_pkg::PH_IDLE;
                     res_valid = 1'b1;
                  end else begin
                     phase_in = mptt_pkg::PH_MEAS_LOW;
                  end
               end
               mptt_pkg::PH_MEAS_LOW: begin
                  phase_in = mptt_pkg::PH_MEAS_HIGH;
                  count_in = count_inc;
               end
               mptt_pkg::PH_MEAS_HIGH: begin
                  count_in = count_inc;
                  done_in  = done_inc;
                  if (done_inc >= cfg.periods_to_measure) begin
                     phase_in  = mptt_pkg::PH_IDLE;
                     res_valid = 1'b1;
                     result.elapsed_ticks = mptt_pkg::ELAPSED_WIDTH'(count_inc);
                  end else begin
                     phase_in = mptt_pkg::PH_MEAS_LOW;
                  end
               end
               default: phase_in = mptt_pkg::PH_IDLE;
            endcase
         end else if (expired) begin
            count_in         = count_inc;
            phase_in         = mptt_pkg::PH_IDLE;
            res_valid        = 1'b1;
            result.timed_out = 1'b1;
         end else begin
            count_in = count_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mptt_pkg::PH_IDLE;
         count_ff <= '0;
         done_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         done_ff  <= done_in;
      end
   end

`ifndef ASSERT_OFF
   a_start_rearms: assert property (@(posedge clock) disable iff (reset)
      step && item.func |=> phase_ff == mptt_pkg::PH_SYNC_LOW && count_ff == '0)
      else $error("start transfer did not re-arm the timer");

   a_result_from_tick: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> step && !item.func && phase_ff != mptt_pkg::PH_IDLE)
      else $error("result raised without a tick in an active phase");

   a_result_to_idle: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> phase_ff == mptt_pkg::PH_IDLE)
      else $error("phase not idle after result");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(phase_ff) && $stable(count_ff) && $stable(done_ff))
      else $error("state moved without a step");

   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      res_valid && result.timed_out |-> result.elapsed_ticks == '0)
      else $error("timeout result carries a non-zero count");
`endif

endmodule

// File: src/multi_period_timer_with_timeout_top.sv
// Flow: a transferred item waits in the input register until the core steps it,
// which it does only while the result register is free; any result is registered
// and offered on rsp_bus until taken. Throughput: one item per cycle while results
// are taken; under an untaken result, the input register refills only when empty.
// Reset: synchronous, active high; clears phase, counters and valid flags and
// restores periods_to_measure = 50 and timeout_ticks = 0xffffff.
module multi_period_timer_with_timeout_top #(
   parameter int unsigned COUNT_WIDTH = 24
) (
   input  logic       clock,
   input  logic       reset,
   mptt_req_if.sink   req_bus,
   mptt_rsp_if.source rsp_bus,
   mptt_csr_if.sink   csr_bus
);

   mptt_pkg::cfg_type    cfg;
   mptt_pkg::item_type   item_ff, item_in;
   logic                 item_valid_ff, item_valid_in;
   mptt_pkg::result_type result, result_ff, result_in;
   logic                 res_valid;
   logic                 out_valid_ff, out_valid_in;
   logic                 out_free;
   logic                 step;

   assign csr_bus.ready = 1'b1;

   mptt_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign step          = item_valid_ff && out_free;
   assign req_bus.ready = !item_valid_ff || out_free;

   mptt_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item_ff),
      .cfg       (cfg),
      .res_valid (res_valid),
      .result    (result)
   );

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff && !step;
      if (req_bus.valid && req_bus.ready) begin
         item_in.func      = req_bus.func;
         item_in.pin_level = req_bus.pin_level;
         item_valid_in     = 1'b1;
      end

      result_in    = result_ff;
      out_valid_in = out_valid_ff && !rsp_bus.ready;
      if (step && res_valid) begin
         result_in    = result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      result_ff <= result_in;
   end

   assign rsp_bus.valid         = out_valid_ff;
   assign rsp_bus.elapsed_ticks = result_ff.elapsed_ticks;
   assign rsp_bus.timed_out     = result_ff.timed_out;

endmodule

// File: verif/multi_period_timer_with_timeout_top_test.sv
// Testbench for multi_period_timer_with_timeout_top: queue-fed request driver, response
// monitor checking against an in-bench period timer model, register writes between phases.
// Depends on mptt_pkg, the mptt channel interfaces and the top level.
module multi_period_timer_with_timeout_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned COUNT_W = 24;
   localparam int IDLE_LIMIT = 3000;
   localparam int LONG_HOLD = 400;
   localparam int MAX_WAIT = 18;

   logic clock;
   logic reset;

   mptt_req_if req_bus ();
   mptt_rsp_if rsp_bus ();
   mptt_csr_if csr_bus ();

   multi_period_timer_with_timeout_top #(.COUNT_WIDTH(COUNT_W)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // timer model state and its copy of the registers
   mptt_pkg::phase_type                timer_phase;
   logic [COUNT_W-1:0]                 window_ticks;
   logic [mptt_pkg::PERIODS_WIDTH-1:0] periods_seen;
   logic [mptt_pkg::PERIODS_WIDTH-1:0] periods_cfg;
   logic [mptt_pkg::TIMEOUT_WIDTH-1:0] timeout_cfg;

   mptt_pkg::item_type   pending_items[$];
   mptt_pkg::result_type timer_results[$];
   mptt_pkg::item_type   offered_item;
   mptt_pkg::result_type predicted;
   mptt_pkg::result_type wanted;
   bit         req_active;
   bit         req_burst;
   bit         rsp_burst;
   int         req_wait;
   int         rsp_wait;
   int         hold_requests;
   int         hold_served;
   int         fail_count;
   int         results_checked;
   int         idle_cycles;
   int         random_items;
   int         seq_budget;

   function automatic bit advance_timer(input mptt_pkg::item_type it,
                                        output mptt_pkg::result_type res);
      res = '0;
      if (it.func) begin
         timer_phase = mptt_pkg::PH_SYNC_LOW;
         window_ticks = '0;
         periods_seen = '0;
         return 0;
      end
      if (timer_phase == mptt_pkg::PH_IDLE) return 0;
      if (window_ticks != '1) window_ticks = window_ticks + 1'b1;
      case (timer_phase)
         mptt_pkg::PH_SYNC_LOW: begin
            if (!it.pin_level) begin
               timer_phase = mptt_pkg::PH_SYNC_HIGH;
               window_ticks = '0;
               return 0;
            end
         end
         mptt_pkg::PH_SYNC_HIGH: begin
            if (it.pin_level) begin
               window_ticks = '0;
               periods_seen = '0;
               if (periods_cfg == '0) begin
                  timer_phase = mptt_pkg::PH_IDLE;
                  return 1;
               end
               timer_phase = mptt_pkg::PH_MEAS_LOW;
               return 0;
            end
         end
         mptt_pkg::PH_MEAS_LOW: begin
            if (!it.pin_level) begin
               timer_phase = mptt_pkg::PH_MEAS_HIGH;
               return 0;
            end
         end
         default: begin
            if (it.pin_level) begin
               periods_seen = periods_seen + 1'b1;
               if (periods_seen >= periods_cfg) begin
                  res.elapsed_ticks = window_ticks;
                  timer_phase = mptt_pkg::PH_IDLE;
                  return 1;
               end
               timer_phase = mptt_pkg::PH_MEAS_LOW;
               return 0;
            end
         end
      endcase
      if (window_ticks >= timeout_cfg || window_ticks == '1) begin
         res.timed_out = 1'b1;
         timer_phase = mptt_pkg::PH_IDLE;
         return 1;
      end
      return 0;
   endfunction

   function automatic int draw_wait(input bit burst);
      return burst ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         timer_phase = mptt_pkg::PH_IDLE;
         window_ticks = '0;
         periods_seen = '0;
         req_active = 1'b0;
         req_burst = 1'b0;
         req_wait = 0;
         req_bus.valid <= 1'b0;
         req_bus.func <= 1'b0;
         req_bus.pin_level <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (advance_timer(offered_item, predicted)) timer_results.push_back(predicted);
            req_active = 1'b0;
         end
         if (!req_active) begin
            if (req_wait > 0) begin
               req_wait--;
            end else if (pending_items.size() > 0) begin
               offered_item = pending_items.pop_front();
               req_active = 1'b1;
               req_bus.func <= offered_item.func;
               req_bus.pin_level <= offered_item.pin_level;
               if ($urandom_range(0, 49) == 0) req_burst = !req_burst;
               req_wait = draw_wait(req_burst);
            end
         end
         req_bus.valid <= req_active;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_wait = 0;
         rsp_burst = 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            results_checked++;
            if (timer_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: elapsed_ticks=%0d timed_out=%0b",
                           rsp_bus.elapsed_ticks, rsp_bus.timed_out);
            end else begin
               wanted = timer_results.pop_front();
               if (rsp_bus.elapsed_ticks !== wanted.elapsed_ticks ||
                   rsp_bus.timed_out !== wanted.timed_out) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: elapsed_ticks exp %0d got %0d, timed_out exp %0b got %0b",
                              wanted.elapsed_ticks, rsp_bus.elapsed_ticks,
                              wanted.timed_out, rsp_bus.timed_out);
               end
            end
            if ($urandom_range(0, 49) == 0) rsp_burst = !rsp_burst;
            rsp_wait = draw_wait(rsp_burst);
         end
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            rsp_wait = LONG_HOLD;
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic queue_item(input bit f, input bit p);
      if (seq_budget > 0) begin
         pending_items.push_back({f, p});
         seq_budget--;
         random_items++;
      end
   endtask

   task automatic queue_run(input bit level, input int max_run);
      repeat ($urandom_range(1, max_run)) queue_item(1'b0, level);
   endtask

   // start, sync to the wave, then the requested number of low/high periods; cut_short ends it early
   task automatic queue_measurement(input int periods, input int max_run, input bit cut_short);
      seq_budget = cut_short ? $urandom_range(1, 10) : 32'h7fff_ffff;
      queue_item(1'b1, 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 2)) queue_item(1'b0, 1'b1);
      queue_run(1'b0, max_run);
      queue_run(1'b1, max_run);
      repeat (periods) begin
         queue_run(1'b0, max_run);
         queue_run(1'b1, max_run);
      end
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(1, 8))
         pending_items.push_back({$urandom_range(0, 4) == 0, 1'($urandom_range(0, 1))});
   endtask

   task automatic queue_fixed(input bit f, input bit p);
      pending_items.push_back({f, p});
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_bus.valid || timer_results.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input mptt_pkg::csr_index_type idx,
                            input logic [mptt_pkg::TIMEOUT_WIDTH-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == mptt_pkg::CSR_PERIODS) periods_cfg = value[mptt_pkg::PERIODS_WIDTH-1:0];
      else timeout_cfg = value;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(input int periods,
                            input logic [mptt_pkg::TIMEOUT_WIDTH-1:0] timeout);
      wait_drained();
      write_reg(mptt_pkg::CSR_PERIODS, mptt_pkg::TIMEOUT_WIDTH'(periods));
      write_reg(mptt_pkg::CSR_TIMEOUT, timeout);
   endtask

   initial begin
      int periods;
      int max_run;
      int phase_no;
      int phase_target;
      int sel;
      logic [mptt_pkg::TIMEOUT_WIDTH-1:0] timeout;

      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = mptt_pkg::CSR_PERIODS;
      csr_bus.data = '0;
      periods_cfg = mptt_pkg::PERIODS_RESET;
      timeout_cfg = mptt_pkg::TIMEOUT_RESET;
      hold_requests = 0;
      random_items = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: idle ticks, restart on start, restart mid measurement
      queue_fixed(1'b0, 1'b0);
      queue_fixed(1'b0, 1'b1);
      queue_fixed(1'b1, 1'b0);
      queue_fixed(1'b1, 1'b1);
      queue_fixed(1'b0, 1'b1);
      queue_fixed(1'b0, 1'b0);
      queue_fixed(1'b0, 1'b1);
      queue_fixed(1'b0, 1'b0);
      queue_fixed(1'b1, 1'b0);
      // zero periods and zero timeout
      configure(0, '0);
      queue_fixed(1'b1, 1'b0);
      queue_fixed(1'b0, 1'b0);
      queue_fixed(1'b0, 1'b1);
      queue_fixed(1'b1, 1'b1);
      queue_fixed(1'b0, 1'b1);
      // one period, longest timeout
      configure(1, '1);
      queue_fixed(1'b1, 1'b1);
      queue_fixed(1'b0, 1'b0);
      queue_fixed(1'b0, 1'b1);
      queue_fixed(1'b0, 1'b0);
      queue_fixed(1'b0, 1'b1);
      // most periods, shortest non-zero timeout
      configure(255, 24'd1);
      queue_fixed(1'b1, 1'b0);
      queue_fixed(1'b0, 1'b0);
      queue_fixed(1'b0, 1'b1);
      queue_fixed(1'b0, 1'b1);

      // one full-length measurement
      configure(255, '1);
      queue_measurement(255, 1, 1'b0);

      phase_no = 0;
      while (random_items < 1300 && phase_no < 40) begin
         case ($urandom_range(0, 5))
            0: timeout = '0;
            1: timeout = 24'd1;
            2: timeout = mptt_pkg::TIMEOUT_WIDTH'($urandom_range(2, 12));
            3: timeout = mptt_pkg::TIMEOUT_WIDTH'($urandom_range(13, 60));
            4: timeout = mptt_pkg::TIMEOUT_WIDTH'($urandom);
            default: timeout = '1;
         endcase
         sel = $urandom_range(0, 9);
         if (sel == 0) periods = 0;
         else if (sel == 1) periods = $urandom_range(6, 255);
         else periods = $urandom_range(1, 5);
         max_run = (timeout <= 12) ? $urandom_range(1, int'(timeout) + 3) : $urandom_range(1, 6);
         configure(periods, timeout);
         if (phase_no == 1) hold_requests <= hold_requests + 1;
         phase_target = random_items + 170;
         while (random_items < phase_target) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) queue_measurement((periods > 8) ? $urandom_range(1, 8) : periods,
                                           max_run, 1'b0);
            else if (sel < 9) queue_measurement(periods, max_run, 1'b1);
            else queue_noise();
         end
         phase_no++;
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// File: multi_period_timer_with_timeout_top.f
src/mptt_pkg.sv
src/mptt_if.sv
src/mptt_csr.sv
src/mptt_core.sv
src/multi_period_timer_with_timeout_top.sv
verif/multi_period_timer_with_timeout_top_test.sv
